/* hdl/spcd_pkg.sv */
// ----------------------------------------------------------------------------
// spcd_pkg
// shared widths, codes and helpers of the segment pair closest distance block
// ----------------------------------------------------------------------------
package spcd_pkg;

	localparam int COORD_BITS = 20;
	localparam int FRAC_BITS  = 16;

	// port field widths
	localparam int FIELD_W = 60;
	localparam int DIST_W  = 60;
	localparam int RATE_W  = 63;
	localparam int LPOS_W  = 17;
	localparam int CASE_W  = 2;
	localparam int DEG_W   = 44;
	localparam int PAR_W   = 64;
	localparam int CFG_W   = 64;

	// internal widths
	localparam int DW = COORD_BITS + 1;          // coordinate difference
	localparam int PW = 2 * DW + 1;              // sum of three products of differences
	localparam int WD = DW + FRAC_BITS + 2;      // offset vector at a closest point
	localparam int MW = (PW > WD) ? PW : WD;     // multiplier operand
	localparam int MH = (MW + 1) / 2;            // low half of a split operand
	localparam int WW = 2 * MW + 3;              // wide sums, quotient operands
	localparam int QW = FRAC_BITS + 1;           // Q1.FRAC_BITS position

	localparam logic [QW-1:0] Q_ONE = QW'(1) << FRAC_BITS;

	typedef logic signed [DW-1:0] diff_t;
	typedef diff_t vec_t [3];

	typedef enum logic [CASE_W-1:0] {
		SC_GENERAL,
		SC_FIRST_DEGEN,
		SC_SECOND_DEGEN,
		SC_PARALLEL
	} solve_case_t;

	typedef enum logic [0:0] {
		CFG_DEGEN_THR,
		CFG_PAR_THR
	} cfg_index_t;

	// dot product of two difference vectors
	function automatic logic signed [PW-1:0] dot3(input vec_t a, input vec_t b);
		logic signed [PW-1:0] s;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			s = s + PW'(a[i]) * PW'(b[i]);
		end
		return s;
	endfunction

endpackage

/* hdl/spcd_req_if.sv */
// ----------------------------------------------------------------------------
// spcd_req_if
// request channel: one segment pair with optional endpoint velocities
// ----------------------------------------------------------------------------
interface spcd_req_if import spcd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] first_start_pos;
	logic [FIELD_W-1:0] first_end_pos;
	logic [FIELD_W-1:0] second_start_pos;
	logic [FIELD_W-1:0] second_end_pos;
	logic [FIELD_W-1:0] first_start_vel;
	logic [FIELD_W-1:0] first_end_vel;
	logic [FIELD_W-1:0] second_start_vel;
	logic [FIELD_W-1:0] second_end_vel;
	logic               has_velocity;

	modport source (
		output valid, first_start_pos, first_end_pos, second_start_pos, second_end_pos,
		output first_start_vel, first_end_vel, second_start_vel, second_end_vel,
		output has_velocity,
		input  ready
	);
	modport sink (
		input  valid, first_start_pos, first_end_pos, second_start_pos, second_end_pos,
		input  first_start_vel, first_end_vel, second_start_vel, second_end_vel,
		input  has_velocity,
		output ready
	);
endinterface

/* hdl/spcd_res_if.sv */
// ----------------------------------------------------------------------------
// spcd_res_if
// result channel: closest positions, squared distance and its rate
// ----------------------------------------------------------------------------
interface spcd_res_if import spcd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [DIST_W-1:0]        min_distance_sq;
	logic signed [RATE_W-1:0] distance_rate;
	logic [LPOS_W-1:0]        pos_on_first;
	logic [LPOS_W-1:0]        pos_on_second;
	logic [CASE_W-1:0]        solve_case;

	modport source (
		output valid, min_distance_sq, distance_rate, pos_on_first, pos_on_second,
		output solve_case,
		input  ready
	);
	modport sink (
		input  valid, min_distance_sq, distance_rate, pos_on_first, pos_on_second,
		input  solve_case,
		output ready
	);
endinterface

/* hdl/segment_pair_closest_distance_top.sv */
// ----------------------------------------------------------------------------
// segment_pair_closest_distance_top
// closest points of two 3d segments, squared distance and its time derivative
// ----------------------------------------------------------------------------
// usage
//   req carries one segment pair per request: four packed endpoints, four
//   packed endpoint velocities and has_velocity. res returns one result per
//   request, in order: both clamped positions, squared distance, its rate and
//   the solve case. cfg_wr_en/cfg_index/cfg_data write the two thresholds;
//   write them only while no request is in flight.
// timing
//   fully pipelined: one request per cycle while res is taken. the depth
//   comes from the bit-per-stage divider (FRAC_BITS + 2 stages) and the
//   two-stage split multipliers.
// reset
//   arst_n clears all valid bits; both thresholds return to 1.
// stall
//   when res is not taken the whole pipeline holds, req.ready drops, and no
//   request is lost or repeated; an empty output slot lets the pipe run on.
// ----------------------------------------------------------------------------
module segment_pair_closest_distance_top import spcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	spcd_req_if.sink         req,
	spcd_res_if.source       res
);

	localparam int DIV_LAT = FRAC_BITS + 2;     // divider stages
	localparam int QSTG    = 7 + DIV_LAT;       // stage where quotients land
	localparam int NSTG    = QSTG + 4;          // total stages incl. output

	typedef struct {
		vec_t d;
		vec_t u;
		vec_t v;
		vec_t vd;
		vec_t vu;
		vec_t vv;
	} side_t;

	// thresholds
	logic [DEG_W-1:0] degen_thr_q;
	logic [PAR_W-1:0] par_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degen_thr_q <= DEG_W'(1);
			par_thr_q   <= PAR_W'(1);
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_DEGEN_THR) begin
				degen_thr_q <= cfg_data[DEG_W-1:0];
			end else begin
				par_thr_q <= cfg_data[PAR_W-1:0];
			end
		end
	end

	// pipeline advance: everything moves unless a finished result is held
	logic            en;
	logic [NSTG-1:0] vld_s;

	assign en        = !vld_s[NSTG-1] || res.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-2:0], req.valid};
		end
	end

	// ---------------- stage 1: unpack and take differences ----------------
	vec_t  p [8];
	side_t side_in;
	vec_t  e1_in, e2_in, e3_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p[0][i] = DW'($signed(req.first_start_pos[i*COORD_BITS +: COORD_BITS]));
			p[1][i] = DW'($signed(req.first_end_pos[i*COORD_BITS +: COORD_BITS]));
			p[2][i] = DW'($signed(req.second_start_pos[i*COORD_BITS +: COORD_BITS]));
			p[3][i] = DW'($signed(req.second_end_pos[i*COORD_BITS +: COORD_BITS]));
			p[4][i] = DW'($signed(req.first_start_vel[i*COORD_BITS +: COORD_BITS]));
			p[5][i] = DW'($signed(req.first_end_vel[i*COORD_BITS +: COORD_BITS]));
			p[6][i] = DW'($signed(req.second_start_vel[i*COORD_BITS +: COORD_BITS]));
			p[7][i] = DW'($signed(req.second_end_vel[i*COORD_BITS +: COORD_BITS]));
			// velocities off: all velocity differences vanish
			if (!req.has_velocity) begin
				p[4][i] = '0;
				p[5][i] = '0;
				p[6][i] = '0;
				p[7][i] = '0;
			end
		end
		for (int i = 0; i < 3; i++) begin
			side_in.u[i]  = p[1][i] - p[0][i];
			side_in.v[i]  = p[3][i] - p[2][i];
			side_in.d[i]  = p[0][i] - p[2][i];
			side_in.vu[i] = p[5][i] - p[4][i];
			side_in.vv[i] = p[7][i] - p[6][i];
			side_in.vd[i] = p[4][i] - p[6][i];
			// endpoint pairs (start,end), (end,start), (end,end)
			e1_in[i] = p[3][i] - p[0][i];
			e2_in[i] = p[2][i] - p[1][i];
			e3_in[i] = p[3][i] - p[1][i];
		end
	end

	side_t side_s [QSTG];
	vec_t  e1_s1, e2_s1, e3_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			e1_s1     <= e1_in;
			e2_s1     <= e2_in;
			e3_s1     <= e3_in;
			for (int k = 1; k < QSTG; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------- stage 2: dot products ----------------
	logic signed [PW-1:0] a_s2, e_s2, bh_s2, ch_s2, dh_s2;
	logic signed [PW-1:0] sq_s2 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2     <= dot3(side_s[0].u, side_s[0].u);
			e_s2     <= dot3(side_s[0].v, side_s[0].v);
			bh_s2    <= dot3(side_s[0].u, side_s[0].d);
			ch_s2    <= dot3(side_s[0].u, side_s[0].v);
			dh_s2    <= -dot3(side_s[0].v, side_s[0].d);
			sq_s2[0] <= dot3(side_s[0].d, side_s[0].d);
			sq_s2[1] <= dot3(e1_s1, e1_s1);
			sq_s2[2] <= dot3(e2_s1, e2_s1);
			sq_s2[3] <= dot3(e3_s1, e3_s1);
		end
	end

	// ---------------- stages 3-4: wide products, case flags ----------------
	logic signed [2*MW-1:0] p_cc, p_ae, p_adh, p_bhch, p_chdh, p_ebh;

	spcd_mul u_mul_cc   (.clk, .en, .a(MW'(ch_s2)), .b(MW'(ch_s2)), .p(p_cc));
	spcd_mul u_mul_ae   (.clk, .en, .a(MW'(a_s2)),  .b(MW'(e_s2)),  .p(p_ae));
	spcd_mul u_mul_adh  (.clk, .en, .a(MW'(a_s2)),  .b(MW'(dh_s2)), .p(p_adh));
	spcd_mul u_mul_bhch (.clk, .en, .a(MW'(bh_s2)), .b(MW'(ch_s2)), .p(p_bhch));
	spcd_mul u_mul_chdh (.clk, .en, .a(MW'(ch_s2)), .b(MW'(dh_s2)), .p(p_chdh));
	spcd_mul u_mul_ebh  (.clk, .en, .a(MW'(e_s2)),  .b(MW'(bh_s2)), .p(p_ebh));

	logic [1:0]           bi_c;
	logic signed [PW-1:0] best_c;

	// nearest endpoint pair, first one wins on ties
	always_comb begin
		bi_c   = 2'd0;
		best_c = sq_s2[0];
		for (int k = 1; k < 4; k++) begin
			if (sq_s2[k] < best_c) begin
				best_c = sq_s2[k];
				bi_c   = 2'(k);
			end
		end
	end

	logic                 deg1_s3, deg2_s3, deg1_s4, deg2_s4;
	logic [1:0]           bi_s3, bi_s4;
	logic signed [PW-1:0] a_s3, e_s3, bh_s3, dh_s3, a_s4, e_s4, bh_s4, dh_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			deg1_s3 <= $unsigned(a_s2) < degen_thr_q;
			deg2_s3 <= $unsigned(e_s2) < degen_thr_q;
			bi_s3   <= bi_c;
			a_s3    <= a_s2;
			e_s3    <= e_s2;
			bh_s3   <= bh_s2;
			dh_s3   <= dh_s2;
			deg1_s4 <= deg1_s3;
			deg2_s4 <= deg2_s3;
			bi_s4   <= bi_s3;
			a_s4    <= a_s3;
			e_s4    <= e_s3;
			bh_s4   <= bh_s3;
			dh_s4   <= dh_s3;
		end
	end

	// ---------------- stage 5: determinant and numerators ----------------
	logic signed [WW-1:0] den_s5, n1_s5, n2_s5;
	logic                 deg1_s5, deg2_s5;
	logic [1:0]           bi_s5;
	logic signed [PW-1:0] a_s5, e_s5, bh_s5, dh_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5  <= WW'(p_cc) - WW'(p_ae);
			n2_s5   <= WW'(p_adh) + WW'(p_bhch);
			n1_s5   <= WW'(p_chdh) + WW'(p_ebh);
			deg1_s5 <= deg1_s4;
			deg2_s5 <= deg2_s4;
			bi_s5   <= bi_s4;
			a_s5    <= a_s4;
			e_s5    <= e_s4;
			bh_s5   <= bh_s4;
			dh_s5   <= dh_s4;
		end
	end

	// ---------------- stage 6: parallel test on |4*den| ----------------
	logic [WW-1:0] gabs;
	assign gabs = (den_s5[WW-1] ? $unsigned(-den_s5) : $unsigned(den_s5)) << 2;

	logic signed [WW-1:0] den_s6, n1_s6, n2_s6;
	logic                 deg1_s6, deg2_s6, par_s6;
	logic [1:0]           bi_s6;
	logic signed [PW-1:0] a_s6, e_s6, bh_s6, dh_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			par_s6  <= gabs < par_thr_q;
			den_s6  <= den_s5;
			n1_s6   <= n1_s5;
			n2_s6   <= n2_s5;
			deg1_s6 <= deg1_s5;
			deg2_s6 <= deg2_s5;
			bi_s6   <= bi_s5;
			a_s6    <= a_s5;
			e_s6    <= e_s5;
			bh_s6   <= bh_s5;
			dh_s6   <= dh_s5;
		end
	end

	// ---------------- stage 7: pick case and divider operands ----------------
	solve_case_t          cs_c;
	logic signed [WW-1:0] num1_c, den1_c, num2_c, den2_c;
	logic                 frc1_c, frc2_c;
	logic [QW-1:0]        fv1_c, fv2_c;

	always_comb begin
		priority if (deg1_s6) begin
			cs_c = SC_FIRST_DEGEN;
		end else if (deg2_s6) begin
			cs_c = SC_SECOND_DEGEN;
		end else if (par_s6) begin
			cs_c = SC_PARALLEL;
		end else begin
			cs_c = SC_GENERAL;
		end
		num1_c = n1_s6;
		den1_c = den_s6;
		num2_c = n2_s6;
		den2_c = den_s6;
		frc1_c = 1'b0;
		frc2_c = 1'b0;
		fv1_c  = '0;
		fv2_c  = '0;
		unique case (cs_c)
			SC_FIRST_DEGEN: begin
				// first is a point: project its start onto the second
				frc1_c = 1'b1;
				frc2_c = deg2_s6;
				num2_c = -WW'(dh_s6);
				den2_c = WW'(e_s6);
			end
			SC_SECOND_DEGEN: begin
				frc2_c = 1'b1;
				num1_c = -WW'(bh_s6);
				den1_c = WW'(a_s6);
			end
			SC_PARALLEL: begin
				frc1_c = 1'b1;
				frc2_c = 1'b1;
				fv1_c  = bi_s6[1] ? Q_ONE : '0;
				fv2_c  = bi_s6[0] ? Q_ONE : '0;
			end
			SC_GENERAL: begin
			end
			default: begin
			end
		endcase
	end

	logic signed [WW-1:0] num1_s7, den1_s7, num2_s7, den2_s7;
	logic                 frc1_s7, frc2_s7;
	logic [QW-1:0]        fv1_s7, fv2_s7;
	solve_case_t          cs_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s7 <= num1_c;
			den1_s7 <= den1_c;
			num2_s7 <= num2_c;
			den2_s7 <= den2_c;
			frc1_s7 <= frc1_c;
			frc2_s7 <= frc2_c;
			fv1_s7  <= fv1_c;
			fv2_s7  <= fv2_c;
			cs_s7   <= cs_c;
		end
	end

	// ---------------- divider stages ----------------
	logic [QW-1:0] l1_q, l2_q;

	spcd_div u_div_first (
		.clk, .en, .num(num1_s7), .den(den1_s7), .frc(frc1_s7), .fval(fv1_s7), .q(l1_q)
	);
	spcd_div u_div_second (
		.clk, .en, .num(num2_s7), .den(den2_s7), .frc(frc2_s7), .fval(fv2_s7), .q(l2_q)
	);

	solve_case_t cs_dly [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			cs_dly[0] <= cs_s7;
			for (int k = 1; k < DIV_LAT; k++) begin
				cs_dly[k] <= cs_dly[k-1];
			end
		end
	end

	// ---------------- offset vector between the closest points ----------------
	logic signed [WD-1:0] l1x, l2x;
	logic signed [WD-1:0] w_c [3];
	logic signed [WD-1:0] vw_c [3];

	assign l1x = WD'($signed({1'b0, l1_q}));
	assign l2x = WD'($signed({1'b0, l2_q}));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w_c[i]  = (WD'(side_s[QSTG-1].d[i]) <<< FRAC_BITS)
				+ WD'(side_s[QSTG-1].u[i]) * l1x - WD'(side_s[QSTG-1].v[i]) * l2x;
			vw_c[i] = (WD'(side_s[QSTG-1].vd[i]) <<< FRAC_BITS)
				+ WD'(side_s[QSTG-1].vu[i]) * l1x - WD'(side_s[QSTG-1].vv[i]) * l2x;
		end
	end

	logic signed [WD-1:0] w_s26 [3];
	logic signed [WD-1:0] vw_s26 [3];
	logic [QW-1:0]        l1_s26, l2_s26, l1_s27, l2_s27, l1_s28, l2_s28;
	solve_case_t          cs_s26, cs_s27, cs_s28;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s26  <= w_c;
			vw_s26 <= vw_c;
			l1_s26 <= l1_q;
			l2_s26 <= l2_q;
			cs_s26 <= cs_dly[DIV_LAT-1];
			l1_s27 <= l1_s26;
			l2_s27 <= l2_s26;
			cs_s27 <= cs_s26;
			l1_s28 <= l1_s27;
			l2_s28 <= l2_s27;
			cs_s28 <= cs_s27;
		end
	end

	// squares and rate products
	logic signed [2*MW-1:0] pww [3];
	logic signed [2*MW-1:0] pvw [3];

	for (genvar i = 0; i < 3; i++) begin : g_axis
		spcd_mul u_mul_ww (.clk, .en, .a(MW'(w_s26[i])),  .b(MW'(w_s26[i])), .p(pww[i]));
		spcd_mul u_mul_vw (.clk, .en, .a(MW'(vw_s26[i])), .b(MW'(w_s26[i])), .p(pvw[i]));
	end

	// ---------------- output register: sum, scale, saturate ----------------
	logic signed [WW-1:0] dsum, rsum, dsh, rsh;
	logic [DIST_W-1:0]    dist_c;
	logic [RATE_W-1:0]    rate_c;

	always_comb begin
		dsum = WW'(pww[0]) + WW'(pww[1]) + WW'(pww[2]);
		rsum = (WW'(pvw[0]) + WW'(pvw[1]) + WW'(pvw[2])) <<< 1;
		dsh  = dsum >>> FRAC_BITS;
		rsh  = rsum >>> FRAC_BITS;
		dist_c = (|dsh[WW-1:DIST_W]) ? {DIST_W{1'b1}} : dsh[DIST_W-1:0];
		// rate fits when everything above its sign bit agrees
		if (&rsh[WW-1:RATE_W-1] || !(|rsh[WW-1:RATE_W-1])) begin
			rate_c = rsh[RATE_W-1:0];
		end else if (rsh[WW-1]) begin
			rate_c = {1'b1, {(RATE_W-1){1'b0}}};
		end else begin
			rate_c = {1'b0, {(RATE_W-1){1'b1}}};
		end
	end

	logic [DIST_W-1:0] dist_s29;
	logic [RATE_W-1:0] rate_s29;
	logic [QW-1:0]     l1_s29, l2_s29;
	solve_case_t       cs_s29;

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s29 <= dist_c;
			rate_s29 <= rate_c;
			l1_s29   <= l1_s28;
			l2_s29   <= l2_s28;
			cs_s29   <= cs_s28;
		end
	end

	assign res.valid           = vld_s[NSTG-1];
	assign res.min_distance_sq = dist_s29;
	assign res.distance_rate   = $signed(rate_s29);
	assign res.pos_on_first    = LPOS_W'(l1_s29);
	assign res.pos_on_second   = LPOS_W'(l2_s29);
	assign res.solve_case      = cs_s29;

endmodule

/* hdl/spcd_mul.sv */
// ----------------------------------------------------------------------------
// spcd_mul
// two-stage signed multiplier, operands split in halves
// ----------------------------------------------------------------------------
module spcd_mul import spcd_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [MW-1:0]   a,
	input  logic signed [MW-1:0]   b,
	output logic signed [2*MW-1:0] p
);

	localparam int HW = MW - MH;

	logic signed [HW-1:0] ah, bh;
	logic        [MH-1:0] al, bl;

	logic signed [2*HW-1:0]  hh_s1;
	logic signed [HW+MH:0]   hl_s1, lh_s1;
	logic        [2*MH-1:0]  ll_s1;
	logic signed [2*MW-1:0]  p_s2;

	assign ah = a[MW-1:MH];
	assign bh = b[MW-1:MH];
	assign al = a[MH-1:0];
	assign bl = b[MH-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= ah * bh;
			hl_s1 <= (HW+MH+1)'(ah) * $signed({1'b0, bl});
			lh_s1 <= (HW+MH+1)'(bh) * $signed({1'b0, al});
			ll_s1 <= al * bl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= ((2*MW)'(hh_s1) <<< (2*MH))
				+ (((2*MW)'(hl_s1) + (2*MW)'(lh_s1)) <<< MH)
				+ $signed((2*MW)'(ll_s1));
		end
	end

	assign p = p_s2;

endmodule

/* hdl/spcd_div.sv */
// ----------------------------------------------------------------------------
// spcd_div
// pipelined restoring divider, one quotient bit per stage, clamped to [0,1]
// ----------------------------------------------------------------------------
module spcd_div import spcd_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [WW-1:0] num,
	input  logic signed [WW-1:0] den,
	input  logic                 frc,
	input  logic [QW-1:0]        fval,
	output logic [QW-1:0]        q
);

	localparam int NS = FRAC_BITS + 1;

	logic [WW-1:0]        nm_s1, dm_s1;
	logic                 frc_s1;
	logic [QW-1:0]        fval_s1;

	logic [WW-1:0]        rem_st [NS];
	logic [WW-1:0]        dm_st  [NS];
	logic [FRAC_BITS-1:0] quo_st [NS];
	logic                 frc_st [NS];
	logic [QW-1:0]        fval_st[NS];

	// sign and zero checks, magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			nm_s1 <= num[WW-1] ? $unsigned(-num) : $unsigned(num);
			dm_s1 <= den[WW-1] ? $unsigned(-den) : $unsigned(den);
			if (frc) begin
				frc_s1  <= 1'b1;
				fval_s1 <= fval;
			end else if (num == '0 || den == '0 || num[WW-1] != den[WW-1]) begin
				frc_s1  <= 1'b1;
				fval_s1 <= '0;
			end else begin
				frc_s1  <= 1'b0;
				fval_s1 <= fval;
			end
		end
	end

	// quotient of one or more clamps to one
	always_ff @(posedge clk) begin
		if (en) begin
			rem_st[0]  <= nm_s1;
			dm_st[0]   <= dm_s1;
			quo_st[0]  <= '0;
			frc_st[0]  <= frc_s1 | (nm_s1 >= dm_s1);
			fval_st[0] <= frc_s1 ? fval_s1 : Q_ONE;
		end
	end

	for (genvar i = 1; i < NS; i++) begin : g_bit
		logic [WW-1:0] sh;
		assign sh = rem_st[i-1] << 1;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[i]  <= (sh >= dm_st[i-1]) ? sh - dm_st[i-1] : sh;
				quo_st[i]  <= {quo_st[i-1][FRAC_BITS-2:0], sh >= dm_st[i-1]};
				dm_st[i]   <= dm_st[i-1];
				frc_st[i]  <= frc_st[i-1];
				fval_st[i] <= fval_st[i-1];
			end
		end
	end

	assign q = frc_st[NS-1] ? fval_st[NS-1] : {1'b0, quo_st[NS-1]};

endmodule
